// ===== rtl/aes128_block_cipher_assert.svh =====
// ----------------------------------------------------------------------------
// AES-128 assertion macros
// Shared concurrent assertion forms for the cipher block.
// ----------------------------------------------------------------------------
`ifndef AES128_BLOCK_CIPHER_ASSERT_SVH
`define AES128_BLOCK_CIPHER_ASSERT_SVH

// same-cycle implication
`define AES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/aes128_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 package
// Constants, S-box tables, round and key schedule functions.
// ----------------------------------------------------------------------------
package aes128_pkg;

  localparam int         RK_IDX_W    = 4;
  localparam logic [3:0] ROUND_COUNT = 4'd10;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  localparam logic IDX_KEY_HIGH = 1'b0;
  localparam logic IDX_KEY_LOW  = 1'b1;

  localparam logic [7:0] GF_POLY = 8'h1b;

  typedef struct packed {
    logic                load;
    logic                expand;
    logic                round;
    logic                last;
    logic                dec;
    logic [RK_IDX_W-1:0] rk_idx;
  } dp_cmd_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  // round constant for expansion step k (1..10)
  function automatic logic [7:0] rcon(input logic [RK_IDX_W-1:0] k);
    logic [7:0] r;
    case (k)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // byte i of the block sits at bits 127-8i downwards
  function automatic logic [127:0] byte_subst(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : FWD_SBOX[s[127-8*i -: 8]];
    end
    return t;
  endfunction

  function automatic logic [127:0] row_rotate(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = inv ? s[127-8*(r+4*((c+4-r)%4)) -: 8]
                                    : s[127-8*(r+4*((c+r)%4)) -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] col_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      t[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return t;
  endfunction

  function automatic logic [7:0] mul9(input logic [7:0] a);
    return xtime(xtime(xtime(a))) ^ a;
  endfunction
  function automatic logic [7:0] mulb(input logic [7:0] a);
    return xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
  endfunction
  function automatic logic [7:0] muld(input logic [7:0] a);
    return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
  endfunction
  function automatic logic [7:0] mule(input logic [7:0] a);
    return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
  endfunction

  function automatic logic [127:0] inv_col_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      t[127-32*c -: 8] = mule(a0) ^ mulb(a1) ^ muld(a2) ^ mul9(a3);
      t[119-32*c -: 8] = mul9(a0) ^ mule(a1) ^ mulb(a2) ^ muld(a3);
      t[111-32*c -: 8] = muld(a0) ^ mul9(a1) ^ mule(a2) ^ mulb(a3);
      t[103-32*c -: 8] = mulb(a0) ^ muld(a1) ^ mul9(a2) ^ mule(a3);
    end
    return t;
  endfunction

  // next 128-bit round key from the previous one
  function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                  input logic [RK_IDX_W-1:0] step);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {FWD_SBOX[w3[23:16]], FWD_SBOX[w3[15:8]], FWD_SBOX[w3[7:0]], FWD_SBOX[w3[31:24]]};
    w0 = w0 ^ t ^ {rcon(step), 24'h0};
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ===== rtl/aes128_dp.sv =====
// ----------------------------------------------------------------------------
// AES-128 datapath
// Key registers, round key store, key expansion step and shared round unit.
// ----------------------------------------------------------------------------
module aes128_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  aes128_pkg::dp_cmd_t   cmd,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [63:0]           cfg_wdata,
  input  logic [63:0]           in_block_high,
  input  logic [63:0]           in_block_low,
  output logic [63:0]           out_high,
  output logic [63:0]           out_low
);
  import aes128_pkg::*;

  logic [63:0]  key_high_r, key_low_r;
  logic [127:0] rk_r [ROUND_COUNT+1];
  logic [127:0] exp_key_r;
  logic [127:0] state_r, state_nxt;
  logic [127:0] rk_sel, exp_nxt;
  logic [127:0] after_sub, after_add;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == IDX_KEY_HIGH) key_high_r <= cfg_wdata;
      else                           key_low_r  <= cfg_wdata;
    end
  end

  // step 0 copies the cipher key, later steps derive from the previous key
  assign exp_nxt = (cmd.rk_idx == '0) ? {key_high_r, key_low_r}
                                      : next_round_key(exp_key_r, cmd.rk_idx);

  always_ff @(posedge clk) begin
    if (cmd.expand) begin
      exp_key_r         <= exp_nxt;
      rk_r[cmd.rk_idx]  <= exp_nxt;
    end
  end

  assign rk_sel = rk_r[cmd.rk_idx];

  always_comb begin
    after_sub = byte_subst(row_rotate(state_r, cmd.dec), cmd.dec);
    after_add = after_sub ^ rk_sel;
    if (cmd.dec) begin
      state_nxt = cmd.last ? after_add : inv_col_mix(after_add);
    end else begin
      state_nxt = (cmd.last ? after_sub : col_mix(after_sub)) ^ rk_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load)       state_r <= {in_block_high, in_block_low} ^ rk_sel;
    else if (cmd.round) state_r <= state_nxt;
  end

  assign out_high = state_r[127:64];
  assign out_low  = state_r[63:0];

endmodule

// ===== rtl/aes128_ctrl.sv =====
// ----------------------------------------------------------------------------
// AES-128 controller
// Sequences key expansion and the round iterations, drives the strobe.
// ----------------------------------------------------------------------------
module aes128_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  in_cmd,
  input  logic                  cfg_we,
  output logic                  busy,
  output logic                  out_valid,
  output aes128_pkg::dp_cmd_t   cmd
);
  import aes128_pkg::*;
  `include "aes128_block_cipher_assert.svh"

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXPAND = 4'b0010,
    ST_ROUND  = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [RK_IDX_W-1:0]   cnt_r, cnt_nxt;
  logic                  dec_r, dec_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dec_nxt   = dec_r;
    cmd       = '0;
    cmd.dec   = dec_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cmd.rk_idx = (in_cmd == CMD_DECRYPT) ? ROUND_COUNT : '0;
          dec_nxt    = in_cmd;
          cnt_nxt    = RK_IDX_W'(1);
          state_nxt  = ST_ROUND;
        end
      end
      ST_EXPAND: begin
        cmd.expand = 1'b1;
        cmd.rk_idx = cnt_r;
        if (cnt_r == ROUND_COUNT) state_nxt = ST_IDLE;
        else                      cnt_nxt   = cnt_r + RK_IDX_W'(1);
      end
      ST_ROUND: begin
        cmd.round  = 1'b1;
        cmd.last   = (cnt_r == ROUND_COUNT);
        cmd.rk_idx = dec_r ? (ROUND_COUNT - cnt_r) : cnt_r;
        if (cnt_r == ROUND_COUNT) state_nxt = ST_DONE;
        else                      cnt_nxt   = cnt_r + RK_IDX_W'(1);
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    // a key write re-runs the whole schedule
    if (cfg_we) begin
      state_nxt = ST_EXPAND;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EXPAND;
      cnt_r   <= '0;
      dec_r   <= CMD_ENCRYPT;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dec_r   <= dec_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

  `AES_ASSERT_NEXT(a_start_busy, start && !busy && !cfg_we, busy, "start not taken")
  `AES_ASSERT_NEXT(a_strobe_once, out_valid, !out_valid, "strobe held")
  `AES_ASSERT_NEXT(a_cfg_expand, cfg_we, state_r == ST_EXPAND, "key write ignored")
  `AES_ASSERT_NOW(a_done_last, out_valid, cnt_r == ROUND_COUNT, "result before last round")

endmodule

// ===== rtl/aes128_block_cipher.sv =====
// ----------------------------------------------------------------------------
// AES-128 block cipher
// FIPS-197 encrypt/decrypt of one 128-bit block per command.
// ----------------------------------------------------------------------------
//  channel | ports                               | transfer when
//  --------+-------------------------------------+---------------------------
//  input   | in_cmd, in_block_high, in_block_low | start high, busy low
//  result  | out_high, out_low                   | out_valid high (one cycle)
//  config  | cfg_index, cfg_wdata                | cfg_we high
//
//  A block passes from transfer to strobe in these steps: the load with the
//  first key addition, ten passes through the single round unit, and the
//  strobe state. A key write expands the schedule one round key per cycle
//  with busy high. Reset clears both key registers and runs the same
//  expansion of the all-zero key before the first block.
//  The receiver cannot stall; the result is shown for one cycle only.
// ----------------------------------------------------------------------------
module aes128_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  output logic        out_valid,
  output logic [63:0] out_high,
  output logic [63:0] out_low,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata
);
  import aes128_pkg::*;

  dp_cmd_t dp_cmd;

  // sequencer: owns round counter and direction
  aes128_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_cmd),
    .cfg_we    (cfg_we),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (dp_cmd)
  );

  // state register, key store and the shared round unit
  aes128_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (dp_cmd),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_block_high (in_block_high),
    .in_block_low  (in_block_low),
    .out_high      (out_high),
    .out_low       (out_low)
  );

endmodule

// ===== dv/aes128_cipher_checker.sv =====
// ----------------------------------------------------------------------------
// AES-128 cipher checker
// Follows key writes and block transfers, keeps its own key schedule,
// predicts each result block and compares it with the strobed output.
// ----------------------------------------------------------------------------
module aes128_cipher_checker
  import aes128_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_cmd,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        out_valid,
  input  logic [63:0] out_high,
  input  logic [63:0] out_low,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          blocks_pending
);

  logic [63:0]  key_hi_r, key_lo_r;
  logic [31:0]  sched_words [44];
  logic [127:0] expected_blocks [$];
  int           mismatch_count;

  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ a;
      a = gf_dbl(a);
    end
    return acc;
  endfunction

  function automatic void expand_schedule(input logic [63:0] hi, input logic [63:0] lo);
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    sched_words[0] = hi[63:32];
    sched_words[1] = hi[31:0];
    sched_words[2] = lo[63:32];
    sched_words[3] = lo[31:0];
    for (int i = 4; i < 44; i++) begin
      t = sched_words[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {FWD_SBOX[t[31:24]], FWD_SBOX[t[23:16]], FWD_SBOX[t[15:8]], FWD_SBOX[t[7:0]]}
            ^ {rc, 24'h0};
        rc = gf_dbl(rc);
      end
      sched_words[i] = sched_words[i-4] ^ t;
    end
  endfunction

  function automatic logic [127:0] cipher_block(input logic dec, input logic [127:0] blk);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [127:0] rk, res;
    logic [7:0]   a0, a1, a2, a3;
    int           src;
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    // round index walks 0..10 for encryption, 10..0 for decryption
    for (int step = 0; step <= 10; step++) begin
      int rnd;
      rnd = dec ? 10 - step : step;
      if (step > 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) begin
            src = dec ? (c + 4 - r) % 4 : (c + r) % 4;
            if (dec) t[r+4*c] = INV_SBOX[s[r+4*src]];
            else     t[r+4*c] = FWD_SBOX[s[r+4*src]];
          end
        s = t;
        if (!dec && step < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            s[4*c]   = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
            s[4*c+1] = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
            s[4*c+2] = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
            s[4*c+3] = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
          end
        end
      end
      rk = {sched_words[4*rnd], sched_words[4*rnd+1], sched_words[4*rnd+2],
            sched_words[4*rnd+3]};
      for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[127-8*i -: 8];
      // inverse mix follows the key addition on the inner decrypt rounds
      if (dec && step > 0 && step < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          s[4*c]   = gf_mul(a0,8'h0e) ^ gf_mul(a1,8'h0b) ^ gf_mul(a2,8'h0d) ^ gf_mul(a3,8'h09);
          s[4*c+1] = gf_mul(a0,8'h09) ^ gf_mul(a1,8'h0e) ^ gf_mul(a2,8'h0b) ^ gf_mul(a3,8'h0d);
          s[4*c+2] = gf_mul(a0,8'h0d) ^ gf_mul(a1,8'h09) ^ gf_mul(a2,8'h0e) ^ gf_mul(a3,8'h0b);
          s[4*c+3] = gf_mul(a0,8'h0b) ^ gf_mul(a1,8'h0d) ^ gf_mul(a2,8'h09) ^ gf_mul(a3,8'h0e);
        end
      end
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  initial begin
    fail_count     = 0;
    blocks_pending = 0;
    mismatch_count = 0;
    key_hi_r       = '0;
    key_lo_r       = '0;
    expand_schedule('0, '0);
  end

  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst_n) begin
      key_hi_r = '0;
      key_lo_r = '0;
      expand_schedule(key_hi_r, key_lo_r);
    end else begin
      if (out_valid) begin
        if (expected_blocks.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result with nothing expected: %h %h", out_high, out_low);
        end else begin
          want = expected_blocks.pop_front();
          if (want[127:64] !== out_high || want[63:0] !== out_low) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("block mismatch: expected %h %h, got %h %h",
                       want[127:64], want[63:0], out_high, out_low);
          end
        end
      end
      if (start && !busy)
        expected_blocks.push_back(cipher_block(in_cmd, {in_block_high, in_block_low}));
      if (cfg_we) begin
        if (cfg_index == IDX_KEY_HIGH) key_hi_r = cfg_wdata;
        else                           key_lo_r = cfg_wdata;
        expand_schedule(key_hi_r, key_lo_r);
      end
    end
    blocks_pending = expected_blocks.size();
  end

endmodule

// ===== dv/tb_aes128_block_cipher.sv =====
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Directed known-answer and extreme blocks, then random blocks under a
// series of keys, with random start gaps; a side checker scores results.
// ----------------------------------------------------------------------------
module tb_aes128_block_cipher;
  import aes128_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_cmd;
  logic [63:0] in_block_high, in_block_low;
  logic        out_valid;
  logic [63:0] out_high, out_low;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_wdata;
  int          fail_count;
  int          blocks_pending;
  int          cycle_count;
  bit          gaps_on;

  // 12-unit clock period
  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  aes128_block_cipher u_top (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_block_high, .in_block_low,
    .out_valid, .out_high, .out_low, .cfg_we, .cfg_index, .cfg_wdata
  );

  aes128_cipher_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_block_high, .in_block_low,
    .out_valid, .out_high, .out_low, .cfg_we, .cfg_index, .cfg_wdata,
    .fail_count, .blocks_pending
  );

  // run watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL aes128_block_cipher");
      $finish;
    end
  end

  // one block transfer; called and returns at a falling edge.
  // busy only moves at rising edges, so its value here holds at the next one.
  task automatic send_block(input logic cmd, input logic [63:0] hi, input logic [63:0] lo);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    start         = 1'b1;
    in_cmd        = cmd;
    in_block_high = hi;
    in_block_low  = lo;
    while (busy) @(negedge clk);
    @(negedge clk);
    start = 1'b0;
  endtask

  // key writes only when drained; each write kicks off an expansion
  task automatic wait_drained();
    while (blocks_pending != 0) @(negedge clk);
    repeat (15) @(negedge clk);
  endtask

  task automatic write_key(input logic idx, input logic [63:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    repeat (2) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  function automatic logic [63:0] rand_half();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // both directions on a batch of boundary blocks
  task automatic directed_pairs();
    logic [63:0] pats [5];
    pats = '{64'h0, '1, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
             64'h0011_2233_4455_6677};
    for (int p = 0; p < 5; p++) begin
      send_block(CMD_ENCRYPT, pats[p], pats[4-p]);
      send_block(CMD_DECRYPT, pats[p], pats[4-p]);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_cmd        = CMD_ENCRYPT;
    in_block_high = '0;
    in_block_low  = '0;
    cfg_we        = 1'b0;
    cfg_index     = IDX_KEY_HIGH;
    cfg_wdata     = '0;
    gaps_on       = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // reset runs an expansion of the all-zero key first
    repeat (2) @(negedge clk);
    while (busy) @(negedge clk);

    // all-zero key straight from reset
    directed_pairs();

    // standard known-answer key
    wait_drained();
    write_key(IDX_KEY_HIGH, 64'h0001_0203_0405_0607);
    write_key(IDX_KEY_LOW,  64'h0809_0a0b_0c0d_0e0f);
    send_block(CMD_ENCRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    send_block(CMD_DECRYPT, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
    send_block(CMD_ENCRYPT, '1, '1);

    // all-ones key, then a partial key update touching only the high half
    wait_drained();
    write_key(IDX_KEY_HIGH, '1);
    write_key(IDX_KEY_LOW,  '1);
    send_block(CMD_ENCRYPT, '0, '0);
    send_block(CMD_DECRYPT, '1, '1);
    wait_drained();
    write_key(IDX_KEY_HIGH, '0);
    send_block(CMD_ENCRYPT, '0, '1);
    send_block(CMD_DECRYPT, '1, '0);

    // random phases, each with a new key or a new key half; the last phases without gaps
    for (int ph = 0; ph < 10; ph++) begin
      wait_drained();
      if (ph >= 8) gaps_on = 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        write_key($urandom_range(0, 1), rand_half());
      end else begin
        write_key(IDX_KEY_HIGH, rand_half());
        write_key(IDX_KEY_LOW,  rand_half());
      end
      repeat (73) send_block($urandom_range(0, 1), rand_half(), rand_half());
    end

    while (blocks_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && blocks_pending == 0) begin
      $display("PASS aes128_block_cipher");
    end else begin
      $display("FAIL aes128_block_cipher");
    end
    $finish;
  end

endmodule

// ===== aes128_block_cipher.f =====
+incdir+rtl
rtl/aes128_pkg.sv
rtl/aes128_dp.sv
rtl/aes128_ctrl.sv
rtl/aes128_block_cipher.sv
dv/aes128_cipher_checker.sv
dv/tb_aes128_block_cipher.sv
